// File: hw/rtl/sparse_gf2_column_store_top_defines.svh
// assertion macros used by the port-level checker of the column store
`ifndef SPARSE_GF2_COLUMN_STORE_TOP_DEFINES_SVH
`define SPARSE_GF2_COLUMN_STORE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SGCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SGCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sgcs_pkg.sv
// types and codes of the sparse gf2 column store
package sgcs_pkg;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_CLOSE = 3'd1,
    OP_ADD   = 3'd2,
    OP_QUERY = 3'd3,
    OP_TWIST = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_STORE_FULL = 2'd2,
    ST_BAD_COLUMN = 2'd3
  } status_t;

  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] CFG_WIDEN_FACTOR = 2'd1;

  localparam logic [10:0] COLUMN_COUNT_RESET = 11'd1024;
  localparam logic [3:0]  WIDEN_FACTOR_RESET = 4'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] row_value;
    logic       closes_column;
    logic [9:0] target_column;
    logic [9:0] source_column;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [10:0] low_row;
    logic        room_to_double;
    logic [14:0] column_length;
  } out_t;

  // write enables of the five memories
  typedef struct packed {
    logic rs;
    logic fe;
    logic ent;
    logic scr;
  } mem_we_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_ADD_1,
    S_ADD_2,
    S_ADD_3,
    S_MRG_RD,
    S_MRG_CMP,
    S_MRG_END,
    S_CPY_RD,
    S_CPY_WR,
    S_DSC_0,
    S_DSC_1,
    S_DSC_2,
    S_TW_RD,
    S_TW_LEN,
    S_TW_LOW,
    S_TW_CLR,
    S_RESP
  } state_t;

endpackage

// File: hw/rtl/sgcs_ram.sv
// generic single-write single-read ram with registered read
module sgcs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/sgcs_ctrl.sv
// sequencer and datapath: load, column add, query and twist over the memories
module sgcs_ctrl #(
  parameter int MAX_COLUMNS    = 1024,
  parameter int ENTRY_CAPACITY = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [10:0]                       column_count,
  input  logic [3:0]                        widen_factor,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sgcs_pkg::in_t                     in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgcs_pkg::out_t                    out_word,
  output sgcs_pkg::mem_we_t                 mem_we,
  output logic [$clog2(MAX_COLUMNS)-1:0]    rs_rd_addr,
  output logic [$clog2(MAX_COLUMNS)-1:0]    fe_rd_addr,
  output logic [$clog2(MAX_COLUMNS)-1:0]    rs_wr_addr,
  output logic [$clog2(MAX_COLUMNS)-1:0]    fe_wr_addr,
  output logic [$clog2(ENTRY_CAPACITY+1)-1:0] rs_wr_data,
  output logic [$clog2(ENTRY_CAPACITY+1)-1:0] fe_wr_data,
  input  logic [$clog2(ENTRY_CAPACITY+1)-1:0] rs_rd_data,
  input  logic [$clog2(ENTRY_CAPACITY+1)-1:0] fe_rd_data,
  output logic [$clog2(ENTRY_CAPACITY)-1:0] ent_wr_addr,
  output logic [9:0]                        ent_wr_data,
  output logic [$clog2(ENTRY_CAPACITY)-1:0] enta_rd_addr,
  output logic [$clog2(ENTRY_CAPACITY)-1:0] entb_rd_addr,
  input  logic [9:0]                        enta_rd_data,
  input  logic [9:0]                        entb_rd_data,
  output logic [$clog2(ENTRY_CAPACITY)-1:0] scr_wr_addr,
  output logic [9:0]                        scr_wr_data,
  output logic [$clog2(ENTRY_CAPACITY)-1:0] scr_rd_addr,
  input  logic [9:0]                        scr_rd_data
);

  import sgcs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int NW = $clog2(MAX_COLUMNS + 1);
  localparam int AW = $clog2(ENTRY_CAPACITY);
  localparam int PW = $clog2(ENTRY_CAPACITY + 1);
  localparam int KW = PW + 1;

  state_t         state_r, state_nxt;
  in_t            in_word_r, in_word_nxt;
  logic [NW-1:0]  lc_r, lc_nxt;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  tu_r, tu_nxt;
  logic [PW-1:0]  rs_t_r, rs_t_nxt;
  logic [PW-1:0]  fe_t_r, fe_t_nxt;
  logic [PW-1:0]  size_r, size_nxt;
  logic [PW-1:0]  len_r, len_nxt;
  logic [PW-1:0]  i_r, i_nxt;
  logic [PW-1:0]  j_r, j_nxt;
  logic [PW-1:0]  e2_r, e2_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [KW-1:0]  idx_r, idx_nxt;
  logic [NW-1:0]  c_r, c_nxt;
  logic [NW-1:0]  lim_r, lim_nxt;
  logic [9:0]     lw_r, lw_nxt;
  status_t        status_r, status_nxt;
  logic [10:0]    low_r, low_nxt;
  logic           room_r, room_nxt;
  logic [14:0]    clen_r, clen_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_word_r, out_word_nxt;

  logic [NW-1:0]  eff;
  logic [3:0]     weff;
  logic           tgt_ok, src_ok, t_has_next, load_bad;
  logic [PW-1:0]  ld_len;
  logic [PW:0]    ld_len_p1;
  logic [PW+4:0]  mul_need;
  logic [PW+5:0]  need;
  logic           store_full;
  logic [PW-1:0]  cl_len;
  logic [PW+3:0]  mul_cl;
  logic [PW+4:0]  cl_end;
  logic [PW-1:0]  cl_tu;
  logic           do_close;
  logic [NW-1:0]  tw_lim;
  logic [PW-1:0]  reg_end, size_calc;
  logic           i_in, j_in, mrg_more, mrg_fail, cpy_done;
  logic           tw_nonempty, tw_hit, tw_last, out_free;
  logic [PW-1:0]  cpy_addr;

  // effective register values
  always_comb begin
    if (column_count == 11'd0) begin
      eff = NW'(1);
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      eff = NW'(MAX_COLUMNS);
    end else begin
      eff = NW'(column_count);
    end
  end
  assign weff = (widen_factor == 4'd0) ? 4'd1 : widen_factor;

  // column checks
  assign tgt_ok = (32'(in_word_r.target_column) < 32'(lc_r))
               && (32'(in_word_r.target_column) < 32'(eff))
               && (32'(in_word_r.target_column) < 32'(MAX_COLUMNS));
  assign src_ok = (32'(in_word_r.source_column) < 32'(lc_r))
               && (32'(in_word_r.source_column) < 32'(eff))
               && (32'(in_word_r.source_column) < 32'(MAX_COLUMNS));
  assign t_has_next = (32'(in_word_r.target_column) + 32'd1 < 32'(lc_r))
                   && (32'(in_word_r.target_column) + 32'd1 < 32'(MAX_COLUMNS));
  assign load_bad = (32'(lc_r) >= 32'(eff)) || (32'(lc_r) >= 32'(MAX_COLUMNS));

  // load and close arithmetic
  assign ld_len     = wp_r - tu_r;
  assign ld_len_p1  = (PW+1)'(ld_len) + (PW+1)'(1);
  assign mul_need   = (PW+5)'(weff) * (PW+5)'(ld_len_p1);
  assign need       = (PW+6)'(tu_r) + (PW+6)'(mul_need);
  assign store_full = (need > (PW+6)'(ENTRY_CAPACITY)) || (wp_r >= PW'(ENTRY_CAPACITY));
  assign cl_len     = (in_word_r.op == OP_LOAD) ? PW'(ld_len_p1) : ld_len;
  assign mul_cl     = (PW+4)'(weff) * (PW+4)'(cl_len);
  assign cl_end     = (PW+5)'(tu_r) + (PW+5)'(mul_cl);
  assign cl_tu      = (cl_end > (PW+5)'(ENTRY_CAPACITY)) ? PW'(ENTRY_CAPACITY)
                                                         : cl_end[PW-1:0];
  assign do_close   = (in_word_r.op == OP_CLOSE)
                   || (in_word_r.closes_column && !store_full);
  assign tw_lim     = (32'(lc_r) < 32'(eff)) ? lc_r : eff;

  // region end of the target column
  assign reg_end   = t_has_next ? rs_rd_data : tu_r;
  assign size_calc = (reg_end >= rs_t_r) ? reg_end - rs_t_r : '0;

  // merge and copy conditions
  assign i_in     = i_r < fe_t_r;
  assign j_in     = j_r < e2_r;
  assign mrg_more = i_in || j_in;
  assign mrg_fail = (k_r > KW'(size_r)) || (k_r > KW'(ENTRY_CAPACITY));
  assign cpy_done = idx_r == k_r;
  assign cpy_addr = rs_t_r + idx_r[PW-1:0];

  // twist conditions
  assign tw_nonempty = fe_rd_data > rs_rd_data;
  assign tw_hit      = 32'(enta_rd_data) < 32'(lim_r);
  assign tw_last     = NW'(c_r + NW'(1)) == lim_r;
  assign out_free    = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (in_word_r.op)
          OP_ADD:   state_nxt = (tgt_ok && src_ok) ? S_ADD_1 : S_RESP;
          OP_QUERY: state_nxt = tgt_ok ? S_DSC_1 : S_RESP;
          OP_TWIST: state_nxt = (tw_lim == '0) ? S_RESP : S_TW_RD;
          default:  state_nxt = S_RESP;
        endcase
      end
      S_ADD_1:   state_nxt = S_ADD_2;
      S_ADD_2:   state_nxt = S_ADD_3;
      S_ADD_3:   state_nxt = S_MRG_RD;
      S_MRG_RD:  state_nxt = mrg_more ? S_MRG_CMP : S_MRG_END;
      S_MRG_CMP: state_nxt = S_MRG_RD;
      S_MRG_END: state_nxt = mrg_fail ? S_DSC_0 : S_CPY_RD;
      S_CPY_RD:  state_nxt = cpy_done ? S_DSC_0 : S_CPY_WR;
      S_CPY_WR:  state_nxt = S_CPY_RD;
      S_DSC_0:   state_nxt = S_DSC_1;
      S_DSC_1:   state_nxt = S_DSC_2;
      S_DSC_2:   state_nxt = S_RESP;
      S_TW_RD:   state_nxt = S_TW_LEN;
      S_TW_LEN: begin
        if (tw_nonempty) begin
          state_nxt = S_TW_LOW;
        end else begin
          state_nxt = tw_last ? S_RESP : S_TW_RD;
        end
      end
      S_TW_LOW: begin
        if (tw_hit) begin
          state_nxt = S_TW_CLR;
        end else begin
          state_nxt = tw_last ? S_RESP : S_TW_RD;
        end
      end
      S_TW_CLR:  state_nxt = tw_last ? S_RESP : S_TW_RD;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    in_word_nxt  = in_word_r;
    lc_nxt       = lc_r;
    wp_nxt       = wp_r;
    tu_nxt       = tu_r;
    rs_t_nxt     = rs_t_r;
    fe_t_nxt     = fe_t_r;
    size_nxt     = size_r;
    len_nxt      = len_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    e2_nxt       = e2_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    c_nxt        = c_r;
    lim_nxt      = lim_r;
    lw_nxt       = lw_r;
    status_nxt   = status_r;
    low_nxt      = low_r;
    room_nxt     = room_r;
    clen_nxt     = clen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt = out_word_r;
    mem_we       = '0;
    rs_rd_addr   = CW'(in_word_r.target_column);
    fe_rd_addr   = CW'(in_word_r.target_column);
    rs_wr_addr   = lc_r[CW-1:0];
    fe_wr_addr   = lc_r[CW-1:0];
    rs_wr_data   = tu_r;
    fe_wr_data   = PW'(tu_r + cl_len);
    ent_wr_addr  = wp_r[AW-1:0];
    ent_wr_data  = in_word_r.row_value;
    enta_rd_addr = i_r[AW-1:0];
    entb_rd_addr = j_r[AW-1:0];
    scr_wr_addr  = k_r[AW-1:0];
    scr_wr_data  = enta_rd_data;
    scr_rd_addr  = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_word_nxt = in_word;
        end
      end
      S_EXEC: begin
        // region reads of the target are issued here for add and query
        status_nxt = ST_OK;
        low_nxt    = '0;
        room_nxt   = 1'b0;
        clen_nxt   = '0;
        unique case (in_word_r.op)
          OP_LOAD, OP_CLOSE: begin
            if (load_bad) begin
              status_nxt = ST_BAD_COLUMN;
            end else if (in_word_r.op == OP_LOAD && store_full) begin
              status_nxt = ST_STORE_FULL;
              clen_nxt   = 15'(ld_len);
            end else begin
              clen_nxt = 15'(cl_len);
              if (in_word_r.op == OP_LOAD) begin
                mem_we.ent = 1'b1;
                wp_nxt     = PW'(wp_r + PW'(1));
              end
              if (do_close) begin
                mem_we.rs = 1'b1;
                mem_we.fe = 1'b1;
                tu_nxt    = cl_tu;
                wp_nxt    = cl_tu;
                lc_nxt    = NW'(lc_r + NW'(1));
              end
            end
          end
          OP_ADD: begin
            if (!(tgt_ok && src_ok)) begin
              status_nxt = ST_BAD_COLUMN;
            end
          end
          OP_QUERY: begin
            if (!tgt_ok) begin
              status_nxt = ST_BAD_COLUMN;
            end
          end
          OP_TWIST: begin
            c_nxt   = '0;
            lim_nxt = tw_lim;
          end
          default: begin
          end
        endcase
      end
      S_ADD_1: begin
        rs_t_nxt   = rs_rd_data;
        fe_t_nxt   = fe_rd_data;
        rs_rd_addr = CW'(32'(in_word_r.target_column) + 32'd1);
        fe_rd_addr = CW'(in_word_r.source_column);
      end
      S_ADD_2: begin
        size_nxt   = size_calc;
        e2_nxt     = fe_rd_data;
        rs_rd_addr = CW'(in_word_r.source_column);
      end
      S_ADD_3: begin
        i_nxt = rs_t_r;
        j_nxt = rs_rd_data;
        k_nxt = '0;
      end
      S_MRG_RD: begin
      end
      S_MRG_CMP: begin
        // one merge step of the symmetric difference
        if (i_in && j_in && enta_rd_data == entb_rd_data) begin
          i_nxt = PW'(i_r + PW'(1));
          j_nxt = PW'(j_r + PW'(1));
        end else begin
          if (i_in && (!j_in || enta_rd_data < entb_rd_data)) begin
            scr_wr_data = enta_rd_data;
            i_nxt       = PW'(i_r + PW'(1));
          end else begin
            scr_wr_data = entb_rd_data;
            j_nxt       = PW'(j_r + PW'(1));
          end
          mem_we.scr = k_r < KW'(ENTRY_CAPACITY);
          k_nxt      = KW'(k_r + KW'(1));
        end
      end
      S_MRG_END: begin
        status_nxt = mrg_fail ? ST_NO_ROOM : ST_OK;
        idx_nxt    = '0;
      end
      S_CPY_RD: begin
        if (cpy_done) begin
          mem_we.fe  = 1'b1;
          fe_wr_addr = CW'(in_word_r.target_column);
          fe_wr_data = PW'(rs_t_r + k_r[PW-1:0]);
        end
      end
      S_CPY_WR: begin
        mem_we.ent  = 1'b1;
        ent_wr_addr = cpy_addr[AW-1:0];
        ent_wr_data = scr_rd_data;
        idx_nxt     = KW'(idx_r + KW'(1));
      end
      S_DSC_0: begin
      end
      S_DSC_1: begin
        rs_t_nxt     = rs_rd_data;
        len_nxt      = (fe_rd_data >= rs_rd_data) ? fe_rd_data - rs_rd_data : '0;
        rs_rd_addr   = CW'(32'(in_word_r.target_column) + 32'd1);
        enta_rd_addr = AW'(fe_rd_data - PW'(1));
      end
      S_DSC_2: begin
        low_nxt  = (len_r == '0) ? 11'(eff) : 11'(enta_rd_data);
        room_nxt = {len_r, 1'b0} <= {1'b0, size_calc};
        clen_nxt = 15'(len_r);
      end
      S_TW_RD: begin
        rs_rd_addr = c_r[CW-1:0];
        fe_rd_addr = c_r[CW-1:0];
      end
      S_TW_LEN: begin
        enta_rd_addr = AW'(fe_rd_data - PW'(1));
        if (!tw_nonempty) begin
          c_nxt = NW'(c_r + NW'(1));
        end
      end
      S_TW_LOW: begin
        lw_nxt     = enta_rd_data;
        rs_rd_addr = CW'(enta_rd_data);
        if (!tw_hit) begin
          c_nxt = NW'(c_r + NW'(1));
        end
      end
      S_TW_CLR: begin
        // empty the column named by the low
        mem_we.fe  = 1'b1;
        fe_wr_addr = CW'(lw_r);
        fe_wr_data = rs_rd_data;
        c_nxt      = NW'(c_r + NW'(1));
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.status         = status_r;
          out_word_nxt.low_row        = low_r;
          out_word_nxt.room_to_double = room_r;
          out_word_nxt.column_length  = clen_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lc_r        <= '0;
      wp_r        <= '0;
      tu_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      wp_r        <= wp_nxt;
      tu_r        <= tu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_word_r  <= in_word_nxt;
    rs_t_r     <= rs_t_nxt;
    fe_t_r     <= fe_t_nxt;
    size_r     <= size_nxt;
    len_r      <= len_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    e2_r       <= e2_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    c_r        <= c_nxt;
    lim_r      <= lim_nxt;
    lw_r       <= lw_nxt;
    status_r   <= status_nxt;
    low_r      <= low_nxt;
    room_r     <= room_nxt;
    clen_r     <= clen_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: hw/rtl/sparse_gf2_column_store_top.sv
// Load, close and unknown ops run the exec and response states; query also passes S_DSC_1 and S_DSC_2.
// Column add reads both regions, merges into scratch and, if it fits, copies back (each merge and copy step waits
// for the registered memory read).
// Twist walks the columns in turn, each through the chained region and entry reads.
// One item in flight; the next word is taken the cycle after its result is registered.
// Reset (synchronous, active low) clears control and config; memories are not cleared.
module sparse_gf2_column_store_top #(
  parameter int MAX_COLUMNS    = 1024,
  parameter int ENTRY_CAPACITY = 16384
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sgcs_pkg::in_t  in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output sgcs_pkg::out_t out_word,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [10:0]    cfg_data
);

  import sgcs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int AW = $clog2(ENTRY_CAPACITY);
  localparam int PW = $clog2(ENTRY_CAPACITY + 1);

  logic [10:0]   column_count_r;
  logic [3:0]    widen_factor_r;
  mem_we_t       mem_we;
  logic [CW-1:0] rs_rd_addr, fe_rd_addr, rs_wr_addr, fe_wr_addr;
  logic [PW-1:0] rs_wr_data, fe_wr_data, rs_rd_data, fe_rd_data;
  logic [AW-1:0] ent_wr_addr, enta_rd_addr, entb_rd_addr, scr_wr_addr, scr_rd_addr;
  logic [9:0]    ent_wr_data, enta_rd_data, entb_rd_data, scr_wr_data, scr_rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COLUMN_COUNT_RESET;
      widen_factor_r <= WIDEN_FACTOR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COLUMN_COUNT) begin
        column_count_r <= cfg_data;
      end else if (cfg_index == CFG_WIDEN_FACTOR) begin
        widen_factor_r <= cfg_data[3:0];
      end
    end
  end

  // region start and fill end per column
  sgcs_ram #(.WIDTH(PW), .DEPTH(MAX_COLUMNS)) u_region_start (
    .clk(clk), .we(mem_we.rs), .wr_addr(rs_wr_addr), .wr_data(rs_wr_data),
    .rd_addr(rs_rd_addr), .rd_data(rs_rd_data)
  );
  sgcs_ram #(.WIDTH(PW), .DEPTH(MAX_COLUMNS)) u_region_fill_end (
    .clk(clk), .we(mem_we.fe), .wr_addr(fe_wr_addr), .wr_data(fe_wr_data),
    .rd_addr(fe_rd_addr), .rd_data(fe_rd_data)
  );

  // entry memory, two mirrored copies so the merge reads both columns at once
  sgcs_ram #(.WIDTH(10), .DEPTH(ENTRY_CAPACITY)) u_entry_a (
    .clk(clk), .we(mem_we.ent), .wr_addr(ent_wr_addr), .wr_data(ent_wr_data),
    .rd_addr(enta_rd_addr), .rd_data(enta_rd_data)
  );
  sgcs_ram #(.WIDTH(10), .DEPTH(ENTRY_CAPACITY)) u_entry_b (
    .clk(clk), .we(mem_we.ent), .wr_addr(ent_wr_addr), .wr_data(ent_wr_data),
    .rd_addr(entb_rd_addr), .rd_data(entb_rd_data)
  );

  // merge scratch
  sgcs_ram #(.WIDTH(10), .DEPTH(ENTRY_CAPACITY)) u_merge_scratch (
    .clk(clk), .we(mem_we.scr), .wr_addr(scr_wr_addr), .wr_data(scr_wr_data),
    .rd_addr(scr_rd_addr), .rd_data(scr_rd_data)
  );

  // sequencer
  sgcs_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .ENTRY_CAPACITY(ENTRY_CAPACITY)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .column_count(column_count_r), .widen_factor(widen_factor_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .mem_we(mem_we),
    .rs_rd_addr(rs_rd_addr), .fe_rd_addr(fe_rd_addr),
    .rs_wr_addr(rs_wr_addr), .fe_wr_addr(fe_wr_addr),
    .rs_wr_data(rs_wr_data), .fe_wr_data(fe_wr_data),
    .rs_rd_data(rs_rd_data), .fe_rd_data(fe_rd_data),
    .ent_wr_addr(ent_wr_addr), .ent_wr_data(ent_wr_data),
    .enta_rd_addr(enta_rd_addr), .entb_rd_addr(entb_rd_addr),
    .enta_rd_data(enta_rd_data), .entb_rd_data(entb_rd_data),
    .scr_wr_addr(scr_wr_addr), .scr_wr_data(scr_wr_data),
    .scr_rd_addr(scr_rd_addr), .scr_rd_data(scr_rd_data)
  );

endmodule

// File: hw/rtl/sgcs_checker.sv
// port-level checker of the column store and its bind
`include "sparse_gf2_column_store_top_defines.svh"

module sgcs_port_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input sgcs_pkg::in_t  in_word,
  input logic           out_valid,
  input logic           out_ready,
  input sgcs_pkg::out_t out_word
);

  import sgcs_pkg::*;

  // stalled words hold
  `SGCS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word), "input word changed while stalled")
  `SGCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // one word in flight: after an accept the input side closes
  `SGCS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second word taken while one is in flight")

  // a rejected column carries no other information
  `SGCS_ASSERT_SAME(a_bad_zero, out_valid && out_word.status == ST_BAD_COLUMN, out_word.low_row == 11'd0 && !out_word.room_to_double && out_word.column_length == 15'd0, "bad column result with nonzero fields")

endmodule

bind sparse_gf2_column_store_top sgcs_port_checker u_sgcs_port_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

// File: dv/sgcs_checker.sv
// column store checker: watches the channels, predicts each result and compares it
module sgcs_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  sgcs_pkg::in_t  in_word,
  input  logic           out_valid,
  input  logic           out_ready,
  input  sgcs_pkg::out_t out_word,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [10:0]    cfg_data,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sgcs_pkg::*;

  localparam int unsigned MAXC = 1024;
  localparam int unsigned CAP  = 16384;

  // shadow registers and store contents
  int unsigned col_count_reg;
  int unsigned widen_reg;
  int unsigned reg_start[MAXC];
  int unsigned reg_fill[MAXC];
  logic [9:0]  entries[CAP];
  logic [9:0]  scratch[CAP];
  int unsigned open_col;
  int unsigned write_ptr;
  int unsigned used_end;

  out_t expected_words[$];

  function automatic int unsigned eff_count();
    if (col_count_reg < 1) return 1;
    if (col_count_reg > MAXC) return MAXC;
    return col_count_reg;
  endfunction

  function automatic int unsigned eff_widen();
    return (widen_reg == 0) ? 1 : widen_reg;
  endfunction

  function automatic logic [9:0] read_entry(int unsigned a);
    return (a < CAP) ? entries[a] : 10'd0;
  endfunction

  function automatic bit col_loaded(int unsigned c);
    return c < open_col && c < eff_count() && c < MAXC;
  endfunction

  function automatic int unsigned region_len(int unsigned c);
    int unsigned e;
    e = (c + 1 < open_col && c + 1 < MAXC) ? reg_start[c + 1] : used_end;
    return (e >= reg_start[c]) ? e - reg_start[c] : 0;
  endfunction

  function automatic int unsigned col_len(int unsigned c);
    return (reg_fill[c] >= reg_start[c]) ? reg_fill[c] - reg_start[c] : 0;
  endfunction

  function automatic int unsigned col_low(int unsigned c);
    if (col_len(c) == 0) return eff_count();
    return 32'(read_entry(reg_fill[c] - 1));
  endfunction

  function automatic out_t describe_col(int unsigned c, status_t st);
    out_t r;
    int unsigned len;
    len = col_len(c);
    r.status = st;
    r.low_row = 11'(col_low(c));
    r.room_to_double = (longint'(len) * 2 <= longint'(region_len(c)));
    r.column_length = 15'(len);
    return r;
  endfunction

  // reserve the region of the open column and move on to the next one
  task automatic close_open(int unsigned len);
    longint unsigned e;
    e = longint'(used_end) + longint'(eff_widen()) * len;
    if (e > CAP) e = CAP;
    reg_start[open_col] = used_end;
    reg_fill[open_col] = used_end + len;
    used_end = 32'(e);
    open_col++;
    write_ptr = used_end;
  endtask

  // symmetric difference of two sorted columns into the target
  task automatic merge_cols(int unsigned t, int unsigned s, output status_t st);
    int unsigned i, e1, j, e2, k;
    logic [9:0] a, b, v;
    i = reg_start[t]; e1 = reg_fill[t];
    j = reg_start[s]; e2 = reg_fill[s];
    k = 0;
    while (i < e1 || j < e2) begin
      if (i < e1 && j < e2) begin
        a = read_entry(i);
        b = read_entry(j);
        if (a < b) begin
          v = a; i++;
        end else if (a > b) begin
          v = b; j++;
        end else begin
          i++; j++;
          continue;
        end
      end else if (i < e1) begin
        v = read_entry(i); i++;
      end else begin
        v = read_entry(j); j++;
      end
      if (k < CAP) scratch[k] = v;
      k++;
    end
    if (k > region_len(t) || k > CAP) begin
      st = ST_NO_ROOM;
      return;
    end
    for (int unsigned n = 0; n < k; n++)
      if (reg_start[t] + n < CAP) entries[reg_start[t] + n] = scratch[n];
    reg_fill[t] = reg_start[t] + k;
    st = ST_OK;
  endtask

  // expected result of one accepted word
  task automatic predict_word(in_t w, output out_t r);
    int unsigned len, lim, lw;
    longint unsigned need;
    status_t st;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      OP_LOAD, OP_CLOSE: begin
        if (open_col >= eff_count() || open_col >= MAXC) begin
          r.status = ST_BAD_COLUMN;
        end else begin
          len = write_ptr - used_end;
          if (w.op == OP_LOAD) begin
            need = longint'(used_end) + longint'(eff_widen()) * (len + 1);
            if (need > CAP || write_ptr >= CAP) begin
              r.status = ST_STORE_FULL;
            end else begin
              entries[write_ptr] = w.row_value;
              write_ptr++;
              len++;
              if (w.closes_column) close_open(len);
            end
          end else begin
            close_open(len);
          end
          r.column_length = 15'(len);
        end
      end
      OP_ADD: begin
        if (!col_loaded(w.target_column) || !col_loaded(w.source_column)) begin
          r.status = ST_BAD_COLUMN;
        end else begin
          merge_cols(w.target_column, w.source_column, st);
          r = describe_col(w.target_column, st);
        end
      end
      OP_QUERY: begin
        if (!col_loaded(w.target_column)) r.status = ST_BAD_COLUMN;
        else r = describe_col(w.target_column, ST_OK);
      end
      OP_TWIST: begin
        lim = (open_col < eff_count()) ? open_col : eff_count();
        for (int unsigned c = 0; c < lim; c++) begin
          lw = col_low(c);
          if (lw < lim) reg_fill[lw] = reg_start[lw];
        end
      end
      default: ;
    endcase
  endtask

  assign pending = expected_words.size();

  // follow the three channels
  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      col_count_reg = 32'(COLUMN_COUNT_RESET);
      widen_reg = 32'(WIDEN_FACTOR_RESET);
      open_col = 0;
      write_ptr = 0;
      used_end = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLUMN_COUNT) col_count_reg = 32'(cfg_data);
        else if (cfg_index == CFG_WIDEN_FACTOR) widen_reg = 32'(cfg_data[3:0]);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: status %0d low %0d room %0d len %0d",
                     out_word.status, out_word.low_row, out_word.room_to_double,
                     out_word.column_length);
        end else begin
          e = expected_words.pop_front();
          if (out_word.status !== e.status || out_word.low_row !== e.low_row ||
              out_word.room_to_double !== e.room_to_double ||
              out_word.column_length !== e.column_length) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: exp st %0d low %0d room %0d len %0d, got st %0d low %0d room %0d len %0d",
                       e.status, e.low_row, e.room_to_double, e.column_length,
                       out_word.status, out_word.low_row, out_word.room_to_double,
                       out_word.column_length);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_word(in_word, e);
        expected_words.insert(expected_words.size(), e);
      end
    end
  end

endmodule

// File: dv/sparse_gf2_column_store_top_test.sv
// column store testbench top: stimulus, output stalls, watchdog and verdict
module sparse_gf2_column_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgcs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_word;
  logic        out_valid;
  logic        out_ready;
  out_t        out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  int          fail_count;
  int          pending;

  int          phase = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  bit          held = 0;
  int          idle_cycles = 0;
  int          words_sent = 0;
  int unsigned col_hint = 0;
  int unsigned next_row = 0;

  always #4 clk = ~clk;

  sparse_gf2_column_store_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sgcs_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_word, .out_valid, .out_ready, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // result side: random stalls, one long hold at the start of the last phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == 3 && !held) begin
      held <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sparse_gf2_column_store_top: mismatch");
      $finish;
    end
  end

  task automatic send_word(in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    words_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain everything in flight before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_row(logic [9:0] row, bit closes);
    in_t w;
    w = '0;
    w.op = OP_LOAD;
    w.row_value = row;
    w.closes_column = closes;
    w.target_column = 10'($urandom);
    w.source_column = 10'($urandom);
    if (closes) col_hint++;
    send_word(w);
  endtask

  task automatic col_op(logic [2:0] op, logic [9:0] t, logic [9:0] s);
    in_t w;
    w = '0;
    w.op = op;
    w.target_column = t;
    w.source_column = s;
    w.row_value = 10'($urandom);
    w.closes_column = 1'($urandom);
    if (op == OP_CLOSE) col_hint++;
    send_word(w);
  endtask

  // next ascending entry of the open column
  task automatic load_next(int unsigned span, bit closes);
    int unsigned row;
    row = next_row + $urandom_range(span);
    if (row >= 1023) begin
      row = 1023;
      closes = 1;
    end
    next_row = closes ? 0 : row + 1;
    load_row(10'(row), closes);
  endtask

  task automatic random_word();
    int r;
    in_t w;
    r = $urandom_range(99);
    if (r < 30) begin
      load_next(40, $urandom_range(3) == 0);
    end else if (r < 34) begin
      next_row = 0;
      col_op(OP_CLOSE, 0, 0);
    end else if (r < 66) begin
      col_op(OP_ADD, 10'($urandom_range(col_hint)), 10'($urandom_range(col_hint)));
    end else if (r < 86) begin
      col_op(OP_QUERY, 10'($urandom_range(col_hint)), 0);
    end else if (r < 91) begin
      col_op(OP_TWIST, 10'($urandom), 10'($urandom));
    end else if (r < 96) begin
      w = in_t'(34'({$urandom, $urandom}));
      if (w.op == OP_LOAD && w.closes_column) next_row = 0;
      send_word(w);
    end else begin
      col_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small columns, adds with fit, no room and self, edge fields
    cfg_write(CFG_COLUMN_COUNT, 11'd1024);
    cfg_write(CFG_WIDEN_FACTOR, 11'd2);
    col_op(OP_QUERY, 0, 0);
    load_row(10'd1, 0);
    load_row(10'd5, 0);
    load_row(10'd9, 1);
    col_op(OP_CLOSE, 0, 0);
    load_row(10'd0, 0);
    load_row(10'd1023, 1);
    load_row(10'd5, 1);
    col_op(OP_QUERY, 0, 0);
    col_op(OP_QUERY, 1, 0);
    col_op(OP_QUERY, 2, 0);
    col_op(OP_ADD, 0, 3);
    col_op(OP_ADD, 3, 2);
    col_op(OP_ADD, 2, 2);
    col_op(OP_ADD, 10'd1023, 0);
    col_op(OP_ADD, 0, 10'd1023);
    col_op(OP_QUERY, 10'd1023, 0);
    col_op(OP_ADD, 2, 3);
    col_op(OP_TWIST, 0, 0);
    col_op(OP_QUERY, 2, 0);
    col_op(OP_SPARE_LO, 10'd1023, 10'd1023);
    col_op(OP_SPARE_HI, 0, 0);
    next_row = 0;

    // three random phases with different stall mixes and settings
    for (int p = 1; p <= 3; p++) begin
      wait_idle();
      case (p)
        1: begin
          cfg_write(CFG_WIDEN_FACTOR, 11'd0);
          cfg_write(CFG_COLUMN_COUNT, 11'd1024);
          send_idle_pct = 19; recv_idle_pct = 76;
        end
        2: begin
          cfg_write(CFG_WIDEN_FACTOR, 11'h7F8);
          cfg_write(CFG_COLUMN_COUNT, 11'd600);
          send_idle_pct = 76; recv_idle_pct = 19;
        end
        default: begin
          cfg_write(CFG_WIDEN_FACTOR, 11'd3);
          cfg_write(CFG_COLUMN_COUNT, 11'd1024);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      phase = p;
      repeat (150) random_word();
    end

    // zero column count acts as one: loading is past the last column
    wait_idle();
    cfg_write(CFG_COLUMN_COUNT, 11'd0);
    col_op(OP_QUERY, 0, 0);
    col_op(OP_QUERY, 1, 0);
    col_op(OP_ADD, 0, 0);
    load_row(10'd3, 0);
    col_op(OP_CLOSE, 0, 0);
    col_op(OP_TWIST, 0, 0);

    // loads at a wide reservation, widen factor 8
    wait_idle();
    cfg_write(CFG_COLUMN_COUNT, 11'd2047);
    cfg_write(CFG_WIDEN_FACTOR, 11'd8);
    repeat (50) load_next(2, $urandom_range(31) == 0);

    // narrower reservation while a column is open, then close with a wider one
    wait_idle();
    cfg_write(CFG_WIDEN_FACTOR, 11'd1);
    repeat (5) load_next(2, 0);
    wait_idle();
    cfg_write(CFG_WIDEN_FACTOR, 11'd8);
    col_op(OP_CLOSE, 0, 0);
    load_next(2, 0);
    repeat (6) col_op(OP_QUERY, 10'($urandom_range(col_hint)), 0);
    repeat (6) col_op(OP_ADD, 10'($urandom_range(col_hint)), 10'($urandom_range(col_hint)));
    col_op(OP_TWIST, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d words: loads, closes, adds, queries, twists and spare ops", words_sent);
    $display("under three stall mixes, a long output hold and register extremes");
    if (fail_count == 0 && pending == 0) begin
      $display("sparse_gf2_column_store_top: match");
    end else begin
      $display("sparse_gf2_column_store_top: mismatch");
    end
    $finish;
  end

endmodule
